/* sv/mwu_pkg.sv */
`timescale 1ns / 1ps
// mwu_pkg: shared types, codes and fixed-point helpers of the momentum weight update
// no dependencies

package mwu_pkg;

    localparam logic       ACT_WEIGHT = 1'b0;
    localparam logic       ACT_BIAS   = 1'b1;

    localparam logic       CFG_LEARNING_RATE  = 1'b0;
    localparam logic       CFG_MOMENTUM_COEFF = 1'b1;

    localparam logic [15:0] LEARNING_RATE_RST  = 16'd655;
    localparam logic [15:0] MOMENTUM_COEFF_RST = 16'd58982;
    localparam logic [15:0] PASS_COUNT_RST     = 16'd1;
    localparam logic [15:0] PASS_COUNT_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [15:0] rem;
        logic        q;
    } div_bit_t;

    // saturate a 33-bit signed sum into Q16.16
    function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
        logic signed [31:0] r;
        if (x[32] != x[31])
        begin
            r = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Q16.16 x Q0.16 product back to Q16.16, truncating toward zero
    function automatic logic signed [31:0] q16_trunc(input logic signed [47:0] p);
        logic signed [47:0] a;
        a = p + (p[47] ? 48'sd65535 : 48'sd0);
        return a[47:16];
    endfunction

    // one restoring division step
    function automatic div_bit_t div_bit(input logic [15:0] rem, input logic b,
                                         input logic [15:0] d);
        logic [16:0] r1;
        div_bit_t    o;
        r1 = {rem, b};
        if (r1 >= {1'b0, d})
        begin
            r1  = r1 - {1'b0, d};
            o.q = 1'b1;
        end
        else
        begin
            o.q = 1'b0;
        end
        o.rem = r1[15:0];
        return o;
    endfunction

endpackage

/* sv/mwu_ram.sv */
`timescale 1ns / 1ps
// mwu_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module mwu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/momentum_weight_update.sv */
`timescale 1ns / 1ps
// momentum_weight_update: sgd-with-momentum parameter update pipeline
// depends on mwu_pkg and mwu_ram

// Takes one parameter word per clock while in_ready is high and returns its updated value, in
// order. The momentum sums live in a RAM of WEIGHT_DEPTH words that is read at accept,
// multiplied and accumulated over two stages and written back; back-to-back updates of
// the same weight are forwarded from those stages. The sum divided by the pass counter
// runs through a 16-stage divider that retires two quotient bits per stage, then the
// learning-rate multiply and the saturating subtract. Results go to a 32-word output
// queue; input ready follows a credit count of words in flight plus queued, so a stalled
// output only blocks the input once 32 words are outstanding. After reset the block
// clears the momentum RAM one word per cycle and accepts no word until it has cleared them all.

module momentum_weight_update #(
    parameter int WEIGHT_DEPTH = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [15:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [11:0]        param_index,
    input  logic signed [31:0] param_value,
    input  logic signed [31:0] gradient,
    input  logic               end_of_pass,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] new_value,
    output logic [11:0]        index_echo
);

    localparam int AW        = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
    localparam int DSTAGES   = 16;
    localparam int QDEPTH    = 32;
    localparam int QAW       = $clog2(QDEPTH);

    // configuration and pass counter
    logic [15:0] lrate_reg;
    logic [15:0] coeff_reg;
    logic [15:0] pass_reg;

    // clearing pass
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    // credit and output queue
    logic [QAW:0]   cred_reg;
    logic [QAW:0]   qcnt_reg;
    logic [QAW-1:0] qwr_reg;
    logic [QAW-1:0] qrd_reg;
    logic [QAW-1:0] q_raddr;
    logic [43:0]    q_wdata;
    logic [43:0]    q_rdata;
    logic           q_fwd_reg;
    logic [43:0]    q_fwd_data_reg;
    logic [43:0]    q_head;

    logic in_acc;
    logic out_acc;

    // stage 1: ram read in flight
    logic               s1_valid_reg;
    logic               s1_weight_reg;
    logic               s1_inrange_reg;
    logic [11:0]        s1_idx_reg;
    logic signed [31:0] s1_value_reg;
    logic signed [31:0] s1_grad_reg;
    logic [15:0]        s1_div_reg;

    // stage 2: decayed sum product
    logic               s2_valid_reg;
    logic               s2_weight_reg;
    logic               s2_inrange_reg;
    logic [11:0]        s2_idx_reg;
    logic signed [31:0] s2_value_reg;
    logic signed [31:0] s2_grad_reg;
    logic [15:0]        s2_div_reg;
    logic signed [47:0] s2_prod_reg;

    // last write-back, kept for forwarding
    logic               s3_wr_reg;
    logic [11:0]        s3_idx_reg;
    logic signed [31:0] s3_sum_reg;

    // divider stages
    logic               dv_valid [0:DSTAGES];
    logic               dv_neg   [0:DSTAGES];
    logic [15:0]        dv_rem   [0:DSTAGES];
    logic [31:0]        dv_work  [0:DSTAGES];
    logic [15:0]        dv_den   [0:DSTAGES];
    logic signed [31:0] dv_value [0:DSTAGES];
    logic [11:0]        dv_idx   [0:DSTAGES];

    // rate multiply stage
    logic               m_valid_reg;
    logic signed [47:0] m_prod_reg;
    logic signed [31:0] m_value_reg;
    logic [11:0]        m_idx_reg;

    logic [31:0]        idx_wide;
    logic               idx_inrange;
    logic [AW-1:0]      rd_addr;
    logic [31:0]        ram_rdata;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [31:0]        s2_idx_wide;

    logic signed [31:0] old_sum;
    logic signed [47:0] s1_prod_full;
    logic signed [31:0] s2_sum;
    logic               s2_wr;
    logic signed [31:0] dv_in;
    logic [15:0]        dv_den_in;
    logic [31:0]        q_mag;
    logic signed [31:0] mom;
    logic signed [47:0] m_prod_full;
    logic signed [31:0] f_result;

    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;
    assign in_ready = !clr_active_reg && (cred_reg != (QAW+1)'(QDEPTH));

    assign idx_wide    = {20'b0, param_index};
    assign idx_inrange = ({5'b0, param_index} < 17'(WEIGHT_DEPTH));
    assign rd_addr     = idx_wide[AW-1:0];
    assign s2_idx_wide = {20'b0, s2_idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lrate_reg <= mwu_pkg::LEARNING_RATE_RST;
            coeff_reg <= mwu_pkg::MOMENTUM_COEFF_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                mwu_pkg::CFG_LEARNING_RATE:  lrate_reg <= cfg_wr_data;
                mwu_pkg::CFG_MOMENTUM_COEFF: coeff_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg <= mwu_pkg::PASS_COUNT_RST;
        end
        else if (in_acc && end_of_pass && (pass_reg != mwu_pkg::PASS_COUNT_MAX))
        begin
            pass_reg <= pass_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(WEIGHT_DEPTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // momentum store
    assign ram_we    = clr_active_reg || s2_wr;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : s2_idx_wide[AW-1:0];
    assign ram_wdata = clr_active_reg ? 32'd0 : s2_sum;

    mwu_ram #(
        .WIDTH (32),
        .DEPTH (WEIGHT_DEPTH)
    ) u_sum_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // stage 1: forward the newest sum of the same weight, then decay
    always_comb
    begin
        if (!s1_inrange_reg)
        begin
            old_sum = 32'sd0;
        end
        else if (s2_wr && (s2_idx_reg == s1_idx_reg))
        begin
            old_sum = s2_sum;
        end
        else if (s3_wr_reg && (s3_idx_reg == s1_idx_reg))
        begin
            old_sum = s3_sum_reg;
        end
        else
        begin
            old_sum = $signed(ram_rdata);
        end
        s1_prod_full = old_sum * $signed({1'b0, coeff_reg});
    end

    // stage 2: add gradient; a bias passes its gradient to the divider over one
    assign s2_sum    = mwu_pkg::sat32(33'(mwu_pkg::q16_trunc(s2_prod_reg))
                                      + 33'(s2_grad_reg));
    assign s2_wr     = s2_valid_reg && (s2_weight_reg == mwu_pkg::ACT_WEIGHT) && s2_inrange_reg;
    assign dv_in     = (s2_weight_reg == mwu_pkg::ACT_WEIGHT) ? s2_sum : s2_grad_reg;
    assign dv_den_in = (s2_weight_reg == mwu_pkg::ACT_WEIGHT) ? s2_div_reg : 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_wr_reg    <= 1'b0;
            dv_valid[0]  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_acc;
            s2_valid_reg <= s1_valid_reg;
            s3_wr_reg    <= s2_wr;
            dv_valid[0]  <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_weight_reg  <= (action == mwu_pkg::ACT_WEIGHT);
        s1_inrange_reg <= idx_inrange && (action == mwu_pkg::ACT_WEIGHT);
        s1_idx_reg     <= param_index;
        s1_value_reg   <= param_value;
        s1_grad_reg    <= gradient;
        s1_div_reg     <= pass_reg;

        s2_weight_reg  <= s1_weight_reg ? mwu_pkg::ACT_WEIGHT : mwu_pkg::ACT_BIAS;
        s2_inrange_reg <= s1_inrange_reg;
        s2_idx_reg     <= s1_idx_reg;
        s2_value_reg   <= s1_value_reg;
        s2_grad_reg    <= s1_grad_reg;
        s2_div_reg     <= s1_div_reg;
        s2_prod_reg    <= s1_prod_full;

        s3_idx_reg     <= s2_idx_reg;
        s3_sum_reg     <= s2_sum;

        dv_neg[0]      <= dv_in[31];
        dv_work[0]     <= dv_in[31] ? (32'd0 - 32'(dv_in)) : 32'(dv_in);
        dv_rem[0]      <= 16'd0;
        dv_den[0]      <= dv_den_in;
        dv_value[0]    <= s2_value_reg;
        dv_idx[0]      <= s2_idx_reg;
    end

    // divider: two quotient bits per stage, quotient shifts in as dividend shifts out
    for (genvar j = 0; j < DSTAGES; j++)
    begin : g_div
        mwu_pkg::div_bit_t b1;
        mwu_pkg::div_bit_t b0;

        always_comb
        begin
            b1 = mwu_pkg::div_bit(dv_rem[j], dv_work[j][31], dv_den[j]);
            b0 = mwu_pkg::div_bit(b1.rem, dv_work[j][30], dv_den[j]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid[j+1] <= 1'b0;
            end
            else
            begin
                dv_valid[j+1] <= dv_valid[j];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_rem[j+1]   <= b0.rem;
            dv_work[j+1]  <= {dv_work[j][29:0], b1.q, b0.q};
            dv_neg[j+1]   <= dv_neg[j];
            dv_den[j+1]   <= dv_den[j];
            dv_value[j+1] <= dv_value[j];
            dv_idx[j+1]   <= dv_idx[j];
        end
    end

    // rate multiply
    assign q_mag       = dv_work[DSTAGES];
    assign mom         = dv_neg[DSTAGES] ? $signed(32'd0 - q_mag) : $signed(q_mag);
    assign m_prod_full = mom * $signed({1'b0, lrate_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= dv_valid[DSTAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        m_prod_reg  <= m_prod_full;
        m_value_reg <= dv_value[DSTAGES];
        m_idx_reg   <= dv_idx[DSTAGES];
    end

    assign f_result = mwu_pkg::sat32(33'(m_value_reg) - 33'(mwu_pkg::q16_trunc(m_prod_reg)));

    // output queue: the head is re-read every cycle, a word landing on the head is bypassed
    assign q_wdata = {f_result, m_idx_reg};
    assign q_raddr = out_acc ? (qrd_reg + QAW'(1)) : qrd_reg;

    mwu_ram #(
        .WIDTH (44),
        .DEPTH (QDEPTH)
    ) u_out_ram (
        .clk   (clk),
        .we    (m_valid_reg),
        .waddr (qwr_reg),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    always_ff @(posedge clk)
    begin
        q_fwd_data_reg <= q_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qwr_reg   <= '0;
            qrd_reg   <= '0;
            qcnt_reg  <= '0;
            cred_reg  <= '0;
            q_fwd_reg <= 1'b0;
        end
        else
        begin
            if (m_valid_reg)
            begin
                qwr_reg <= qwr_reg + QAW'(1);
            end
            if (out_acc)
            begin
                qrd_reg <= qrd_reg + QAW'(1);
            end
            qcnt_reg  <= qcnt_reg + (QAW+1)'(m_valid_reg) - (QAW+1)'(out_acc);
            cred_reg  <= cred_reg + (QAW+1)'(in_acc) - (QAW+1)'(out_acc);
            q_fwd_reg <= m_valid_reg && (qwr_reg == q_raddr);
        end
    end

    assign q_head     = q_fwd_reg ? q_fwd_data_reg : q_rdata;
    assign out_valid  = (qcnt_reg != '0);
    assign new_value  = $signed(q_head[43:12]);
    assign index_echo = q_head[11:0];

    // checks
    a_cred_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cred_reg <= (QAW+1)'(QDEPTH)) && (qcnt_reg <= cred_reg))
        else $error("credit count out of range");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (qcnt_reg != (QAW+1)'(QDEPTH)))
        else $error("output queue written while full");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !in_ready && !s1_valid_reg)
        else $error("word accepted during clearing pass");

    a_pass_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        pass_reg != 16'd0)
        else $error("pass counter reached zero");

endmodule
